// ===== rtl/sobel_et_pkg.sv =====
// shared types, constants and codes for the sobel edge threshold block
package sobel_et_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;

	localparam int PIX_W    = 8;
	localparam int GRAY_W   = 8;
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int ROW_W    = $clog2(MAX_HEIGHT);
	localparam int WIDTH_W  = 12;
	localparam int HEIGHT_W = 13;
	localparam int THR_W    = 21;
	localparam int MAG_W    = 21;
	localparam int CFG_W    = 21;
	localparam int CFG_IDX_W = 2;

	// gray = (r + g + b) / 3 via reciprocal, exact for sums up to 765
	localparam int SUM_W        = 10;
	localparam int RECIP3       = 683;
	localparam int RECIP3_SHIFT = 11;
	localparam int PROD3_W      = 20;

	localparam int WSUM_W = 10;
	localparam int GRAD_W = 11;
	localparam int SQ_W   = 20;

	localparam int LINE_DW = 2 * GRAY_W;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;

	localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(3);
	localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
	localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);
	localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = HEIGHT_W'(MAX_HEIGHT);
	localparam logic [WIDTH_W-1:0]  WIDTH_RST    = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST   = HEIGHT_W'(480);
	localparam logic [THR_W-1:0]    THRESH_RST   = THR_W'(10000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_THRESH = 2'd2
	} cfg_reg_t;

	// position info that travels with a pixel down the pipe
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} pos_t;

	typedef struct packed {
		pos_t             pos;
		logic [MAG_W-1:0] mag;
		logic             is_edge;
	} result_t;

endpackage

// ===== rtl/sobel_et_ram.sv =====
// generic single-port-write, registered-read ram
module sobel_et_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/sobel_et_grad.sv =====
// 3x3 window, sobel gradients, squaring and threshold compare
module sobel_et_grad (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  pix_valid,
	input  logic                                  pix_report,
	input  sobel_et_pkg::pos_t                    pix_pos,
	input  logic [sobel_et_pkg::GRAY_W-1:0]       pix_top,
	input  logic [sobel_et_pkg::GRAY_W-1:0]       pix_mid,
	input  logic [sobel_et_pkg::GRAY_W-1:0]       pix_gray,
	input  logic [sobel_et_pkg::THR_W-1:0]        threshold,
	output logic                                  res_valid,
	output sobel_et_pkg::result_t                 res,
	output logic [1:0]                            busy_cnt
);

	// window: [0..2] two columns back, [3..5] one column back (top..bottom)
	logic [sobel_et_pkg::GRAY_W-1:0] win_q [6];

	logic [sobel_et_pkg::WSUM_W-1:0] wl_x, wr_x, wl_y, wr_y;
	logic signed [sobel_et_pkg::GRAD_W-1:0] gx, gy;

	logic                                   v_s2;
	sobel_et_pkg::pos_t                     pos_s2;
	logic signed [sobel_et_pkg::GRAD_W-1:0] gx_s2, gy_s2;

	logic signed [2*sobel_et_pkg::GRAD_W-1:0] sqx_full, sqy_full;

	logic                              v_s3;
	sobel_et_pkg::pos_t                pos_s3;
	logic [sobel_et_pkg::SQ_W-1:0]     sqx_s3, sqy_s3;
	logic [sobel_et_pkg::MAG_W-1:0]    mag;

	always_comb begin
		wl_x = sobel_et_pkg::WSUM_W'(win_q[0]) + {1'b0, win_q[1], 1'b0}
			+ sobel_et_pkg::WSUM_W'(win_q[2]);
		wr_x = sobel_et_pkg::WSUM_W'(pix_top) + {1'b0, pix_mid, 1'b0}
			+ sobel_et_pkg::WSUM_W'(pix_gray);
		wl_y = sobel_et_pkg::WSUM_W'(win_q[0]) + {1'b0, win_q[3], 1'b0}
			+ sobel_et_pkg::WSUM_W'(pix_top);
		wr_y = sobel_et_pkg::WSUM_W'(win_q[2]) + {1'b0, win_q[5], 1'b0}
			+ sobel_et_pkg::WSUM_W'(pix_gray);
		gx = $signed({1'b0, wl_x}) - $signed({1'b0, wr_x});
		gy = $signed({1'b0, wl_y}) - $signed({1'b0, wr_y});
	end

	// window shifts on every pixel, reported or not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (pix_valid) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= pix_top;
			win_q[4] <= pix_mid;
			win_q[5] <= pix_gray;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= pix_valid & pix_report;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		pos_s2 <= pix_pos;
		gx_s2  <= gx;
		gy_s2  <= gy;
		pos_s3 <= pos_s2;
		sqx_s3 <= sqx_full[sobel_et_pkg::SQ_W-1:0];
		sqy_s3 <= sqy_full[sobel_et_pkg::SQ_W-1:0];
	end

	// squares are non-negative and below 2^20
	assign sqx_full = gx_s2 * gx_s2;
	assign sqy_full = gy_s2 * gy_s2;
	assign mag      = sobel_et_pkg::MAG_W'(sqx_s3) + sobel_et_pkg::MAG_W'(sqy_s3);

	assign res_valid   = v_s3;
	assign res.pos     = pos_s3;
	assign res.mag     = mag;
	assign res.is_edge = (mag >= threshold);

	assign busy_cnt = 2'(pix_valid & pix_report) + 2'(v_s2) + 2'(v_s3);

endmodule

// ===== rtl/sobel_et_ofifo.sv =====
// small result queue between the pipe and the output channel
module sobel_et_ofifo (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  sobel_et_pkg::result_t            push_data,
	input  logic                             pop,
	output logic                             not_empty,
	output sobel_et_pkg::result_t            head,
	output logic [sobel_et_pkg::FIFO_CW-1:0] level
);

	sobel_et_pkg::result_t               ent_q [sobel_et_pkg::FIFO_DEPTH];
	logic [sobel_et_pkg::FIFO_AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [sobel_et_pkg::FIFO_CW-1:0]    cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign not_empty = (cnt_q != '0);
	assign head      = ent_q[rd_ptr_q];
	assign level     = cnt_q;

endmodule

// ===== rtl/sobel_edge_threshold_top.sv =====
// top level of the streaming sobel edge detector with threshold
//
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------------
// pixel in | in_valid / in_ready  | red, green, blue, frame_start
// result   | out_valid / out_ready| out_row, out_col, magnitude, is_edge, frame_last
// config   | cfg_wr_en            | cfg_index, cfg_data (no read-back)
//
// one pixel per clock while in_ready holds; a result passes s1, s2, s3 and the queue
// the line ram (one 16-bit entry per column, both rows above) is read on accept and
// written back in the next cycle; a back-to-back hit on the same column is forwarded
// an 8-entry result queue decouples the output; in_ready drops only when queue
// plus in-flight results could fill it, so output stalls hold the pixel stream
// reset clears counters, window, queue and config to defaults; no ram clearing pass
module sobel_edge_threshold_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// pixel input
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [sobel_et_pkg::PIX_W-1:0]        red,
	input  logic [sobel_et_pkg::PIX_W-1:0]        green,
	input  logic [sobel_et_pkg::PIX_W-1:0]        blue,
	input  logic                                  frame_start,
	// result output
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [sobel_et_pkg::ROW_W-1:0]        out_row,
	output logic [sobel_et_pkg::COL_W-1:0]        out_col,
	output logic [sobel_et_pkg::MAG_W-1:0]        magnitude,
	output logic                                  is_edge,
	output logic                                  frame_last,
	// configuration writes
	input  logic                                  cfg_wr_en,
	input  logic [sobel_et_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sobel_et_pkg::CFG_W-1:0]        cfg_data
);

	// config registers, stored already clamped to the legal range
	logic [sobel_et_pkg::WIDTH_W-1:0]  width_q;
	logic [sobel_et_pkg::HEIGHT_W-1:0] height_q;
	logic [sobel_et_pkg::THR_W-1:0]    thresh_q;
	logic [sobel_et_pkg::WIDTH_W-1:0]  cfg_w;
	logic [sobel_et_pkg::HEIGHT_W-1:0] cfg_h;

	// raster position of the next pixel
	logic [sobel_et_pkg::COL_W-1:0] col_q;
	logic [sobel_et_pkg::ROW_W-1:0] row_q;
	logic [sobel_et_pkg::COL_W-1:0] col_cur;
	logic [sobel_et_pkg::ROW_W-1:0] row_cur;
	logic                           col_wrap;
	logic                           row_wrap;

	logic                           accept;
	logic                           report;
	sobel_et_pkg::pos_t             pos_cur;

	// gray conversion
	logic [sobel_et_pkg::SUM_W-1:0]   rgb_sum;
	logic [sobel_et_pkg::PROD3_W-1:0] rgb_prod;
	logic [sobel_et_pkg::GRAY_W-1:0]  gray_cur;

	// stage 1: ram data back
	logic                            v_s1;
	logic                            report_s1;
	sobel_et_pkg::pos_t              pos_s1;
	logic [sobel_et_pkg::COL_W-1:0]  addr_s1;
	logic [sobel_et_pkg::GRAY_W-1:0] gray_s1;
	logic                            fwd_s1;
	logic [sobel_et_pkg::LINE_DW-1:0] fwd_data_s1;

	logic [sobel_et_pkg::LINE_DW-1:0] ram_rdata;
	logic [sobel_et_pkg::LINE_DW-1:0] line_s1;
	logic [sobel_et_pkg::LINE_DW-1:0] line_wdata;
	logic [sobel_et_pkg::GRAY_W-1:0]  top_s1;
	logic [sobel_et_pkg::GRAY_W-1:0]  mid_s1;

	logic                                  res_valid;
	sobel_et_pkg::result_t                 res;
	logic [1:0]                            busy_cnt;

	logic                                  q_not_empty;
	sobel_et_pkg::result_t                 q_head;
	logic [sobel_et_pkg::FIFO_CW-1:0]      q_level;
	logic [sobel_et_pkg::FIFO_CW:0]        q_committed;

	// clamp incoming config values
	always_comb begin
		cfg_w = cfg_data[sobel_et_pkg::WIDTH_W-1:0];
		if (cfg_w < sobel_et_pkg::WIDTH_MIN) begin
			cfg_w = sobel_et_pkg::WIDTH_MIN;
		end else if (cfg_w > sobel_et_pkg::WIDTH_MAX) begin
			cfg_w = sobel_et_pkg::WIDTH_MAX;
		end
		cfg_h = cfg_data[sobel_et_pkg::HEIGHT_W-1:0];
		if (cfg_h < sobel_et_pkg::HEIGHT_MIN) begin
			cfg_h = sobel_et_pkg::HEIGHT_MIN;
		end else if (cfg_h > sobel_et_pkg::HEIGHT_MAX) begin
			cfg_h = sobel_et_pkg::HEIGHT_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sobel_et_pkg::WIDTH_RST;
			height_q <= sobel_et_pkg::HEIGHT_RST;
			thresh_q <= sobel_et_pkg::THRESH_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				sobel_et_pkg::REG_WIDTH:  width_q  <= cfg_w;
				sobel_et_pkg::REG_HEIGHT: height_q <= cfg_h;
				sobel_et_pkg::REG_THRESH: thresh_q <= cfg_data[sobel_et_pkg::THR_W-1:0];
				default: ;  // unknown index is ignored
			endcase
		end
	end

	// accept only while queue plus in-flight results leave room
	assign q_committed = {1'b0, q_level} + (sobel_et_pkg::FIFO_CW + 1)'(busy_cnt);
	assign in_ready    = (q_committed < (sobel_et_pkg::FIFO_CW + 1)'(sobel_et_pkg::FIFO_DEPTH));
	assign accept      = in_valid & in_ready;

	// frame_start puts this pixel at (0,0)
	assign col_cur = frame_start ? '0 : col_q;
	assign row_cur = frame_start ? '0 : row_q;

	always_comb begin
		col_wrap = ({1'b0, col_cur} + 1'b1) >= width_q;
		row_wrap = ({1'b0, row_cur} + 1'b1) >= height_q;
		// a full window exists and the position lies inside the frame
		report = (row_cur >= sobel_et_pkg::ROW_W'(2)) && (col_cur >= sobel_et_pkg::COL_W'(2))
			&& ({1'b0, col_cur} < width_q) && ({1'b0, row_cur} < height_q);
		pos_cur.row  = row_cur - 1'b1;
		pos_cur.col  = col_cur - 1'b1;
		pos_cur.last = ({1'b0, row_cur} == height_q - 1'b1)
			&& ({1'b0, col_cur} == width_q - 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_cur + 1'b1;
			end else begin
				col_q <= col_cur + 1'b1;
				row_q <= row_cur;
			end
		end
	end

	// gray = sum / 3 by reciprocal multiply
	assign rgb_sum  = sobel_et_pkg::SUM_W'(red) + sobel_et_pkg::SUM_W'(green)
		+ sobel_et_pkg::SUM_W'(blue);
	assign rgb_prod = sobel_et_pkg::PROD3_W'(rgb_sum) * sobel_et_pkg::PROD3_W'(sobel_et_pkg::RECIP3);
	assign gray_cur = rgb_prod[sobel_et_pkg::RECIP3_SHIFT +: sobel_et_pkg::GRAY_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	// same column written back this edge: ram returns the old entry, so forward
	always_ff @(posedge clk) begin
		report_s1   <= report;
		pos_s1      <= pos_cur;
		addr_s1     <= col_cur;
		gray_s1     <= gray_cur;
		fwd_s1      <= v_s1 && (addr_s1 == col_cur);
		fwd_data_s1 <= line_wdata;
	end

	assign line_s1    = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign top_s1     = line_s1[sobel_et_pkg::LINE_DW-1:sobel_et_pkg::GRAY_W];
	assign mid_s1     = line_s1[sobel_et_pkg::GRAY_W-1:0];
	// row above moves up to two-above, this pixel becomes the row above
	assign line_wdata = {mid_s1, gray_s1};

	sobel_et_ram #(
		.WIDTH (sobel_et_pkg::LINE_DW),
		.DEPTH (sobel_et_pkg::MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (v_s1),
		.waddr (addr_s1),
		.wdata (line_wdata),
		.re    (accept),
		.raddr (col_cur),
		.rdata (ram_rdata)
	);

	sobel_et_grad u_grad (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (v_s1),
		.pix_report (report_s1),
		.pix_pos    (pos_s1),
		.pix_top    (top_s1),
		.pix_mid    (mid_s1),
		.pix_gray   (gray_s1),
		.threshold  (thresh_q),
		.res_valid  (res_valid),
		.res        (res),
		.busy_cnt   (busy_cnt)
	);

	sobel_et_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (q_not_empty & out_ready),
		.not_empty (q_not_empty),
		.head      (q_head),
		.level     (q_level)
	);

	assign out_valid  = q_not_empty;
	assign out_row    = q_head.pos.row;
	assign out_col    = q_head.pos.col;
	assign magnitude  = q_head.mag;
	assign is_edge    = q_head.is_edge;
	assign frame_last = q_head.pos.last;

endmodule

// ===== rtl/sobel_et_chk.sv =====
// port-level checker for the sobel edge threshold block, bound to the top level
module sobel_et_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [sobel_et_pkg::ROW_W-1:0] out_row,
	input logic [sobel_et_pkg::COL_W-1:0] out_col,
	input logic [sobel_et_pkg::MAG_W-1:0] magnitude,
	input logic                           is_edge,
	input logic                           frame_last
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
			&& $stable(magnitude) && $stable(is_edge) && $stable(frame_last))
		else $error("result changed while stalled");

	// only interior pixels are reported
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_row != '0) && (out_col != '0))
		else $error("border pixel reported");

	// squared magnitude of a 3x3 sobel stays in range
	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> magnitude <= sobel_et_pkg::MAG_W'(2080800))
		else $error("magnitude out of range");

endmodule

bind sobel_edge_threshold_top sobel_et_chk u_chk (.*);
